>>> rtl/cbm_pkg.sv
// cbm_pkg: shared types and constants for the conditional block matcher.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int INDEX_BITS        = 16;
  localparam int ENTRY_BITS        = INDEX_BITS + 1;  // kind bit above the index
  localparam int OPEN_BITS         = 7;
  localparam int ERR_BITS          = 3;
  localparam int STACK_DEPTH_DEF   = 64;

  typedef enum logic [1:0] {
    OP_IF    = 2'd0,
    OP_ELSE  = 2'd1,
    OP_ENDIF = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_OK    = 3'd0,
    ERR_ELSE  = 3'd1,
    ERR_ENDIF = 3'd2,
    ERR_OP    = 3'd3,
    ERR_FULL  = 3'd4
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

>>> rtl/conditional_block_matcher.sv
// Conditional block matcher: if/else/endif matching on a stack in memory.
// Timing: an accepted input beat is registered together with the stack read of
// the top entry; the execute state then registers the result beat.
// Markers: no new marker is taken until the execute step of the last one is over;
// each marker reads the top entry from the stack RAM and then
// writes back / moves the top. A held result beat stalls the input.
// Reset: stack top cleared to empty, output beat dropped; the stack RAM is
// not cleared, no clearing pass, block ready right after reset.
`timescale 1ns / 1ps

module conditional_block_matcher #(
  parameter int STACK_DEPTH = cbm_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [cbm_pkg::INDEX_BITS-1:0]  in_object_index,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_link_valid,
  output logic [cbm_pkg::INDEX_BITS-1:0]  out_link_source,
  output logic [cbm_pkg::INDEX_BITS-1:0]  out_link_target,
  output logic [cbm_pkg::ERR_BITS-1:0]    out_error_code,
  output logic                            out_stack_is_empty,
  output logic [cbm_pkg::OPEN_BITS-1:0]   out_open_entries
);

  import cbm_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int TOP_W = $clog2(STACK_DEPTH + 1);

  state_t                 state_r, state_nxt;
  logic [TOP_W-1:0]       top_r, top_nxt;
  op_t                    op_r;
  logic [INDEX_BITS-1:0]  obj_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   link_r, link_nxt;
  logic [INDEX_BITS-1:0]  src_r, src_nxt;
  logic [INDEX_BITS-1:0]  dst_r, dst_nxt;
  err_t                   err_r, err_nxt;
  logic                   empty_r, empty_nxt;
  logic [OPEN_BITS-1:0]   open_r, open_nxt;

  logic                   in_accept;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [ENTRY_BITS-1:0]  rd_data;
  logic                   wr_en;
  logic [ENTRY_BITS-1:0]  wr_data;
  logic                   full, empty, top_kind;

  cbm_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (top_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs: take a beat only when idle and the result slot frees up
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
        rd_en    = in_valid && !in_stall;
      end
      ST_EXEC: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign rd_addr   = top_r[AW-1:0] - AW'(1);  // top entry; don't care when empty

  assign full     = (top_r == TOP_W'(STACK_DEPTH));
  assign empty    = (top_r == '0);
  assign top_kind = rd_data[ENTRY_BITS-1];

  // execute step with the top entry in hand
  always_comb begin
    top_nxt = top_r;
    wr_en   = 1'b0;
    wr_data = {1'b0, obj_r};
    link_nxt = 1'b0;
    src_nxt  = '0;
    dst_nxt  = '0;
    err_nxt  = ERR_OK;
    if (state_r == ST_EXEC) begin
      unique case (op_r)
        OP_IF: begin
          if (full) begin
            err_nxt = ERR_FULL;
          end else begin
            wr_en   = 1'b1;
            top_nxt = top_r + TOP_W'(1);
          end
        end
        OP_ELSE: begin
          priority if (empty) begin
            err_nxt = ERR_ELSE;
          end else if (full) begin
            err_nxt = ERR_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_data  = {1'b1, obj_r};
            top_nxt  = top_r + TOP_W'(1);
            link_nxt = 1'b1;
            src_nxt  = rd_data[INDEX_BITS-1:0];
            dst_nxt  = obj_r;
          end
        end
        OP_ENDIF: begin
          if (empty) begin
            err_nxt = ERR_ENDIF;
          end else begin
            // else on top pops its if too, when one lies below
            if (top_kind && (top_r >= TOP_W'(2))) top_nxt = top_r - TOP_W'(2);
            else                                  top_nxt = top_r - TOP_W'(1);
            link_nxt = 1'b1;
            src_nxt  = rd_data[INDEX_BITS-1:0];
            dst_nxt  = obj_r;
          end
        end
        OP_BAD: err_nxt = ERR_OP;
        default: err_nxt = ERR_OP;
      endcase
    end
  end

  assign empty_nxt = (top_nxt == '0);
  assign open_nxt  = OPEN_BITS'(top_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_EXEC)          out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= op_t'(in_opcode);
      obj_r <= in_object_index;
    end
    if (state_r == ST_EXEC) begin
      link_r  <= link_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      err_r   <= err_nxt;
      empty_r <= empty_nxt;
      open_r  <= open_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_link_valid     = link_r;
  assign out_link_source    = src_r;
  assign out_link_target    = dst_r;
  assign out_error_code     = err_r;
  assign out_stack_is_empty = empty_r;
  assign out_open_entries   = open_r;

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_W'(STACK_DEPTH))
    else $error("stack top beyond depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_EXEC)
    else $error("accepted beat not executed");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EXEC)
    else $error("result beat without execute step");

  a_top_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |=> $stable(top_r))
    else $error("stack top moved while idle");

  a_link_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && link_r |-> err_r == ERR_OK)
    else $error("link reported with error");
`endif

endmodule

>>> rtl/cbm_stack_ram.sv
// cbm_stack_ram: single-clock stack storage, one write and one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module cbm_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
